FILE: hw/rtl/size_class_block_allocator_top_defines.svh
// ============================================================================
// Size class block allocator: assertion macros
// Concurrent checks that are compiled for simulation and empty for synthesis.
// ============================================================================
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SCBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SCBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCBA_ASSERT_SAME(lbl, ante, cons, msg)
`define SCBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/scba_pkg.sv
// ============================================================================
// Size class block allocator package
// Default sizing, operation and status codes, control state type.
// ============================================================================
package scba_pkg;

    localparam int NUM_CLASSES_DEF      = 8;
    localparam int CLASS_SHIFT_DEF      = 6;
    localparam int BLOCKS_PER_CLASS_DEF = 16;

    localparam int SIZE_W  = 20;
    localparam int FCLS_W  = 3;
    localparam int FIDX_W  = 4;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERSIZE  = 2'd1,
        STAT_EXHAUSTED = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

endpackage

FILE: hw/rtl/size_class_block_allocator_top.sv
// ============================================================================
// Size class block allocator
// Segregated free-list allocator: per-class LIFO of freed blocks kept as a
// linked list in a link memory, backed by a fresh-block counter per class.
// ============================================================================
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------
//  request | in        | i_in_valid / o_in_ready   | func, req_size, free_*
//  result  | out       | o_out_valid / i_out_ready | status, block_*, size
//
//  A transaction has an accept cycle, which reads the link memory at the
//  class's stack top, and an execute cycle, which pops, pushes or takes a
//  fresh block and loads the result register. A new request is taken only
//  in the idle state, so not while a transaction is in its execute state.
//  Reset (synchronous, active low) empties every stack and fresh counter.
//  A stalled result holds the execute cycle; no request is taken meanwhile.
// ============================================================================
`include "size_class_block_allocator_top_defines.svh"

module size_class_block_allocator_top
    import scba_pkg::*;
#(
    parameter int NUM_CLASSES      = NUM_CLASSES_DEF,
    parameter int CLASS_SHIFT      = CLASS_SHIFT_DEF,
    parameter int BLOCKS_PER_CLASS = BLOCKS_PER_CLASS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic [SIZE_W-1:0] i_req_size,
    input  logic [FCLS_W-1:0] i_free_class,
    input  logic [FIDX_W-1:0] i_free_index,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic [2:0]        o_block_class,
    output logic [3:0]        o_block_index,
    output logic [SIZE_W-1:0] o_granted_size
);

    // class and index widths follow the pool geometry
    localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int IDX_W      = $clog2(BLOCKS_PER_CLASS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int LINK_W     = IDX_W + 1;           // {valid, index below}
    localparam int ADDR_W     = CLS_W + IDX_W;
    localparam int LINK_DEPTH = 2 ** ADDR_W;
    localparam int CMP_W      = 11;                  // holds BLOCKS_PER_CLASS and NUM_CLASSES

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state             r_state, n_state;

    logic [IDX_W-1:0]   r_top   [NUM_CLASSES];
    logic               r_ne    [NUM_CLASSES];
    logic [CNT_W-1:0]   r_fresh [NUM_CLASSES];

    // link memory: entry for a block holds the block below it on the stack
    logic [LINK_W-1:0]  r_link_mem [LINK_DEPTH];
    logic [LINK_W-1:0]  r_link;

    // request captured at accept
    t_func              r_func;
    logic [SIZE_W-1:0]  r_size;
    logic               r_over;
    logic [CLS_W-1:0]   r_cls;
    logic               r_free_ok;
    logic [CLS_W-1:0]   r_fcls_c;
    logic [IDX_W-1:0]   r_fidx_c;
    logic [FCLS_W-1:0]  r_fcls;
    logic [FIDX_W-1:0]  r_fidx;

    // result register
    logic               r_out_valid;
    t_status            r_status;
    logic [2:0]         r_block_class;
    logic [3:0]         r_block_index;
    logic [SIZE_W-1:0]  r_granted_size;

    // ------------------------------------------------------------------
    // Accept side: class decode and link memory address
    // ------------------------------------------------------------------
    logic               w_accept;
    logic [SIZE_W-1:0]  w_size_m1;
    logic [SIZE_W-1:0]  w_cls_full;
    logic               w_in_over;
    logic [CLS_W-1:0]   w_in_cls;
    logic               w_in_free_ok;
    logic [ADDR_W-1:0]  w_rd_addr;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_size_m1  = i_req_size - SIZE_W'(1);
    // a size of zero maps to class 0
    assign w_cls_full = (i_req_size == '0) ? '0 : (w_size_m1 >> CLASS_SHIFT);
    assign w_in_over  = (w_cls_full >= SIZE_W'(NUM_CLASSES));
    assign w_in_cls   = w_in_over ? '0 : w_cls_full[CLS_W-1:0];
    assign w_in_free_ok = (CMP_W'(i_free_class) < CMP_W'(NUM_CLASSES)) &&
                          (CMP_W'(i_free_index) < CMP_W'(BLOCKS_PER_CLASS));
    assign w_rd_addr  = {w_in_cls, r_top[w_in_cls]};

    // ------------------------------------------------------------------
    // Execute side
    // ------------------------------------------------------------------
    logic               w_exec_fire;
    logic [IDX_W-1:0]   w_top;
    logic               w_ne;
    logic [CNT_W-1:0]   w_fresh;
    logic [SIZE_W-1:0]  w_gsize;
    logic               w_do_push;
    logic               w_do_pop;
    logic               w_do_fresh;
    t_status            w_res_status;
    logic [2:0]         w_res_class;
    logic [3:0]         w_res_index;
    logic [SIZE_W-1:0]  w_res_size;

    assign w_exec_fire = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);
    assign w_top       = r_top[r_cls];
    assign w_ne        = r_ne[r_cls];
    assign w_fresh     = r_fresh[r_cls];
    assign w_gsize     = (SIZE_W'(r_cls) + SIZE_W'(1)) << CLASS_SHIFT;

    always_comb begin
        w_do_push    = 1'b0;
        w_do_pop     = 1'b0;
        w_do_fresh   = 1'b0;
        w_res_status = STAT_OK;
        w_res_class  = '0;
        w_res_index  = '0;
        w_res_size   = '0;
        priority if (r_func == FUNC_FREE) begin
            // out-of-range frees are echoed but change nothing
            w_do_push   = r_free_ok;
            w_res_class = r_fcls;
            w_res_index = r_fidx;
        end else if (r_over) begin
            w_res_status = STAT_OVERSIZE;
            w_res_size   = r_size;
        end else if (w_ne) begin
            // most recently freed block first
            w_do_pop    = 1'b1;
            w_res_class = 3'(r_cls);
            w_res_index = 4'(w_top);
            w_res_size  = w_gsize;
        end else if (w_fresh < CNT_W'(BLOCKS_PER_CLASS)) begin
            w_do_fresh  = 1'b1;
            w_res_class = 3'(r_cls);
            w_res_index = 4'(w_fresh);
            w_res_size  = w_gsize;
        end else begin
            w_res_status = STAT_EXHAUSTED;
            w_res_class  = 3'(r_cls);
        end
    end

    // ------------------------------------------------------------------
    // Control FSM
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_exec_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Request capture and link memory
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func    <= t_func'(i_func);
            r_size    <= i_req_size;
            r_over    <= w_in_over;
            r_cls     <= w_in_cls;
            r_free_ok <= w_in_free_ok;
            r_fcls_c  <= CLS_W'(i_free_class);
            r_fidx_c  <= IDX_W'(i_free_index);
            r_fcls    <= i_free_class;
            r_fidx    <= i_free_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_link <= r_link_mem[w_rd_addr];
        end
    end

    // push: new block links to the previous top
    always_ff @(posedge i_clk) begin
        if (w_exec_fire && w_do_push) begin
            r_link_mem[{r_fcls_c, r_fidx_c}] <= {r_ne[r_fcls_c], r_top[r_fcls_c]};
        end
    end

    // ------------------------------------------------------------------
    // Per-class stack tops and fresh counters
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_top[c]   <= '0;
                r_ne[c]    <= 1'b0;
                r_fresh[c] <= '0;
            end
        end else if (w_exec_fire) begin
            if (w_do_push) begin
                r_top[r_fcls_c] <= r_fidx_c;
                r_ne[r_fcls_c]  <= 1'b1;
            end
            if (w_do_pop) begin
                r_top[r_cls] <= r_link[IDX_W-1:0];
                r_ne[r_cls]  <= r_link[LINK_W-1];
            end
            if (w_do_fresh) begin
                r_fresh[r_cls] <= w_fresh + CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec_fire) begin
            r_status       <= w_res_status;
            r_block_class  <= w_res_class;
            r_block_index  <= w_res_index;
            r_granted_size <= w_res_size;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_block_class  = r_block_class;
    assign o_block_index  = r_block_index;
    assign o_granted_size = r_granted_size;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic               w_exhausted;
    logic               w_pool_dry;

    assign w_exhausted = w_exec_fire && (w_res_status == STAT_EXHAUSTED);
    assign w_pool_dry  = !w_ne && (w_fresh == CNT_W'(BLOCKS_PER_CLASS));

    `SCBA_ASSERT_NEXT(a_accept_exec, w_accept, r_state == ST_EXEC, "accept did not start execute")
    `SCBA_ASSERT_NEXT(a_exec_result, w_exec_fire, o_out_valid && r_state == ST_IDLE, "result lost")
    `SCBA_ASSERT_SAME(a_exhaust_full, w_exhausted, w_pool_dry, "exhausted with blocks left")

endmodule
